@@ rtl/core/sitd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitd_pkg
// Types and constants shared by the strip index triangle decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sitd_pkg;

  localparam int INDEX_BITS = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
  localparam logic [2:0] POS_LIMIT = 3'd4;

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef enum logic [1:0] {
    PH_LENGTH   = 2'd0,
    PH_ENTRIES  = 2'd1,
    PH_COMPLETE = 2'd2,
    PH_EMPTY    = 2'd3
  } phase_t;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        tri_valid;
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic [15:0] third_index;
    logic        done_res;
    logic [1:0]  end_status;
    logic [30:0] entries_decoded;
  } out_item_t;

  // Decoded request passed from the byte front end to the strip back end.
  typedef struct packed {
    logic        has_entry;
    logic [31:0] value;
    logic        form_tri;
    logic        odd;
    logic        last;
    logic [1:0]  status;
    logic [30:0] entries;
  } q_item_t;

  function automatic logic [15:0] to_out_index(input index_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sitd_front.sv @@
// ----------------------------------------------------------------------------
// sitd_front
// Byte front end: varint assembly, strip length, entry counting and status.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_front (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic accept,
  input  sitd_pkg::in_item_t in_data,
  output logic               push,
  output sitd_pkg::q_item_t  push_data
);
  import sitd_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] varint_accum, varint_accum_next;
  logic [2:0]  varint_byte_pos, varint_byte_pos_next;
  logic [30:0] strip_total, strip_total_next;
  logic [30:0] entry_count, entry_count_next;

  logic        active;
  logic        val_done;
  logic [31:0] part;
  logic [31:0] value;
  logic [30:0] entry_inc;
  logic [6:0]  payload;

  assign active   = (phase == PH_LENGTH) || (phase == PH_ENTRIES);
  assign payload  = in_data.data_byte[6:0] & PAYLOAD_MASK;
  assign val_done = active && !in_data.data_byte[7];
  assign entry_inc = entry_count + 31'd1;

  always_comb begin
    case (varint_byte_pos)
      3'd0:    part = 32'(payload);
      3'd1:    part = 32'(payload) << 7;
      3'd2:    part = 32'(payload) << 14;
      3'd3:    part = 32'(payload) << 21;
      3'd4:    part = 32'(payload) << 28;
      default: part = '0;
    endcase
    value = varint_accum | part;
  end

  // Next state and datapath registers.
  always_comb begin
    phase_next           = phase;
    varint_accum_next    = varint_accum;
    varint_byte_pos_next = varint_byte_pos;
    strip_total_next     = strip_total;
    entry_count_next     = entry_count;
    if (active) begin
      if (varint_byte_pos <= POS_LIMIT) begin
        varint_accum_next    = value;
        varint_byte_pos_next = varint_byte_pos + 3'd1;
      end
      if (val_done) begin
        varint_accum_next    = '0;
        varint_byte_pos_next = '0;
        if (phase == PH_LENGTH) begin
          if (value == 32'd0 || value[31]) begin
            phase_next = PH_EMPTY;
          end else begin
            strip_total_next = value[30:0];
            phase_next       = PH_ENTRIES;
          end
        end else begin
          entry_count_next = entry_inc;
          if (entry_inc >= strip_total) begin
            phase_next = PH_COMPLETE;
          end
        end
      end
    end
  end

  // Request toward the back end.
  always_comb begin
    push_data.has_entry = val_done && (phase == PH_ENTRIES);
    push_data.value     = value;
    push_data.form_tri  = entry_count >= 31'd2;
    push_data.odd       = entry_count[0];
    push_data.last      = in_data.last_byte;
    push_data.entries   = entry_count_next;
    push_data.status    = ST_COMPLETE;
    if (in_data.last_byte) begin
      case (phase_next)
        PH_COMPLETE: push_data.status = ST_COMPLETE;
        PH_EMPTY:    push_data.status = ST_EMPTY;
        default:     push_data.status = ST_TRUNCATED;
      endcase
    end
    push = accept && (push_data.has_entry || in_data.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LENGTH;
      varint_accum    <= '0;
      varint_byte_pos <= '0;
      strip_total     <= '0;
      entry_count     <= '0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        phase           <= PH_LENGTH;
        varint_accum    <= '0;
        varint_byte_pos <= '0;
        strip_total     <= '0;
        entry_count     <= '0;
      end else begin
        phase           <= phase_next;
        varint_accum    <= varint_accum_next;
        varint_byte_pos <= varint_byte_pos_next;
        strip_total     <= strip_total_next;
        entry_count     <= entry_count_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sitd_queue.sv @@
// ----------------------------------------------------------------------------
// sitd_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_queue (
  input  wire               logic clk,
  input  wire               logic rst,
  input  wire               logic push,
  input  sitd_pkg::q_item_t push_data,
  output logic              full,
  input  wire               logic pop,
  output logic              not_empty,
  output sitd_pkg::q_item_t pop_data
);
  import sitd_pkg::*;

  q_item_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full      = count == QCNT_BITS'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sitd_back.sv @@
// ----------------------------------------------------------------------------
// sitd_back
// Strip back end: entry reconstruction, triangle forming and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_back (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic q_valid,
  input  sitd_pkg::q_item_t   q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 logic out_ready,
  output sitd_pkg::out_item_t out_data
);
  import sitd_pkg::*;

  index_t    zero_count;
  index_t    older_entry;
  index_t    newer_entry;
  index_t    entry;
  logic      tri_hit;
  logic      has_result;
  out_item_t result;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // The new entry counts down from the zero counter.
  assign entry = zero_count - q_data.value[INDEX_BITS-1:0];

  always_comb begin
    tri_hit = q_data.has_entry && q_data.form_tri &&
              (older_entry != newer_entry) && (older_entry != entry) &&
              (newer_entry != entry);
    has_result = tri_hit || q_data.last;
    result.tri_valid       = tri_hit;
    result.first_index     = '0;
    result.second_index    = '0;
    result.third_index     = '0;
    result.done_res        = q_data.last;
    result.end_status      = q_data.status;
    result.entries_decoded = q_data.entries;
    if (tri_hit) begin
      result.first_index = to_out_index(older_entry);
      if (q_data.odd) begin
        result.second_index = to_out_index(entry);
        result.third_index  = to_out_index(newer_entry);
      end else begin
        result.second_index = to_out_index(newer_entry);
        result.third_index  = to_out_index(entry);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_count  <= '0;
      older_entry <= '0;
      newer_entry <= '0;
    end else if (q_pop) begin
      if (q_data.last) begin
        zero_count  <= '0;
        older_entry <= '0;
        newer_entry <= '0;
      end else if (q_data.has_entry) begin
        if (q_data.value == 32'd0) begin
          zero_count <= zero_count + INDEX_BITS'(1);
        end
        older_entry <= newer_entry;
        newer_entry <= entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/strip_index_triangle_decoder.sv @@
// ----------------------------------------------------------------------------
// strip_index_triangle_decoder
// Decodes a varint-coded triangle strip index buffer into triangles.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (data_byte, last_byte)
// out      output     out_valid / out_ready  out_data  (triangle and end status)
//
// One byte is accepted per cycle while the request queue is not full; its
// result passes through the request queue into the result register.
// The front end stalls only when the two-entry request queue is full, and the
// back end drains it whenever the result register is empty or being taken.
// Reset is synchronous and clears all control and strip state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_index_triangle_decoder (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic in_valid,
  output logic                in_ready,
  input  sitd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 logic out_ready,
  output sitd_pkg::out_item_t out_data
);
  import sitd_pkg::*;

  logic    accept;
  logic    push;
  q_item_t push_data;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_data;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  sitd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  sitd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  sitd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
